// File: hdl/smart_card_char_tx_rx_core_defines.svh
//------------------------------------------------------------------------------
// Smart-card character engine assertion macros
// Shared concurrent assertion forms for the character engine.
//------------------------------------------------------------------------------
`ifndef SMART_CARD_CHAR_TX_RX_CORE_DEFINES_SVH
`define SMART_CARD_CHAR_TX_RX_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCTRX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sctrx: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SCTRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sctrx: next-cycle check failed");

`endif

// File: hdl/sctrx_pkg.sv
//------------------------------------------------------------------------------
// Smart-card character engine package
// Types, codes and constants shared by the character engine modules.
//------------------------------------------------------------------------------
package sctrx_pkg;

    localparam logic [7:0]  MAX_RESPONSE   = 8'd255;
    localparam logic [7:0]  BYTE_COUNT_TOP = 8'hFF;
    localparam logic [7:0]  BAD_BYTE       = 8'hEE;
    localparam logic [15:0] ETU_RESET      = 16'd834;
    localparam logic [15:0] IDLE_RESET     = 16'd8000;

    // configuration register indexes
    localparam logic [0:0]  CFG_ETU_TICKS    = 1'b0;
    localparam logic [0:0]  CFG_IDLE_TIMEOUT = 1'b1;

    // transmit frame phases, counting down
    localparam logic [3:0]  PH_START      = 4'd14;
    localparam logic [3:0]  PH_DATA_HI    = 4'd13;
    localparam logic [3:0]  PH_DATA_LO    = 4'd6;
    localparam logic [3:0]  PH_PARITY     = 4'd5;
    localparam logic [3:0]  PH_ERR_SAMPLE = 4'd4;
    localparam logic [3:0]  PH_END        = 4'd0;

    // receive bit positions
    localparam logic [3:0]  RXB_WAIT    = 4'd0;
    localparam logic [3:0]  RXB_START   = 4'd1;
    localparam logic [3:0]  RXB_DATA_LO = 4'd2;
    localparam logic [3:0]  RXB_DATA_HI = 4'd9;
    localparam logic [3:0]  RXB_PARITY  = 4'd10;
    localparam logic [3:0]  RXB_GUARD   = 4'd11;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] etu_ticks;
        logic [15:0] idle_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       line_in;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
    } item_t;

    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       tx_taken;
        logic       card_error;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_parity_error;
        logic       rx_done;
        logic [7:0] rx_count;
    } result_t;

    typedef struct packed {
        mode_t mode;
    } status_t;

endpackage

// File: hdl/sctrx_if.sv
//------------------------------------------------------------------------------
// Smart-card character engine channels
// Valid/ready channels for tick items and per-tick results.
//------------------------------------------------------------------------------
interface sctrx_in_if;
    logic       valid;
    logic       ready;
    logic       line_in;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, line_in, tx_valid, tx_byte, tx_last, input ready);
    modport sink   (input valid, line_in, tx_valid, tx_byte, tx_last, output ready);
endinterface

interface sctrx_out_if;
    logic       valid;
    logic       ready;
    logic       line_out;
    logic       line_drive;
    logic       tx_taken;
    logic       card_error;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_parity_error;
    logic       rx_done;
    logic [7:0] rx_count;

    modport source (output valid, line_out, line_drive, tx_taken, card_error, rx_valid,
                    rx_byte, rx_parity_error, rx_done, rx_count, input ready);
    modport sink   (input valid, line_out, line_drive, tx_taken, card_error, rx_valid,
                    rx_byte, rx_parity_error, rx_done, rx_count, output ready);
endinterface

// File: hdl/smart_card_char_tx_rx_core.sv
//------------------------------------------------------------------------------
// Smart-card character engine top level
// Input register, per-tick engine and result register on valid/ready channels.
//------------------------------------------------------------------------------
// An accepted tick beat is held in the input register and its result in the
// result register. Throughput: one tick beat per cycle while out_ch does not
// stall; the engine step is combinational logic between the two registers.
// Reset: rst_n clears both stages, the engine to idle and the config to
// etu_ticks 834 and idle_timeout_ticks 8000.
module smart_card_char_tx_rx_core
(
    input  logic        clk,
    input  logic        rst_n,
    sctrx_in_if.sink    in_ch,
    sctrx_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sctrx_pkg::*;
    `include "smart_card_char_tx_rx_core_defines.svh"

    cfg_t    cfg;
    status_t status;
    result_t eng_result;

    logic    in_full_reg,  in_full_next;
    item_t   item_reg;
    logic    out_full_reg, out_full_next;
    result_t res_reg;

    logic    advance;
    logic    step;
    logic    in_take;

    assign advance     = !out_full_reg || out_ch.ready;
    assign step        = in_full_reg && advance;
    assign in_ch.ready = !in_full_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    sctrx_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sctrx_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .item   (item_reg),
        .result (eng_result),
        .status (status)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (step)
        begin
            in_full_next = 1'b0;
        end
        out_full_next = advance ? step : out_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.line_in  <= in_ch.line_in;
            item_reg.tx_valid <= in_ch.tx_valid;
            item_reg.tx_byte  <= in_ch.tx_byte;
            item_reg.tx_last  <= in_ch.tx_last;
        end
        if (step)
        begin
            res_reg <= eng_result;
        end
    end

    assign out_ch.valid           = out_full_reg;
    assign out_ch.line_out        = res_reg.line_out;
    assign out_ch.line_drive      = res_reg.line_drive;
    assign out_ch.tx_taken        = res_reg.tx_taken;
    assign out_ch.card_error      = res_reg.card_error;
    assign out_ch.rx_valid        = res_reg.rx_valid;
    assign out_ch.rx_byte         = res_reg.rx_byte;
    assign out_ch.rx_parity_error = res_reg.rx_parity_error;
    assign out_ch.rx_done         = res_reg.rx_done;
    assign out_ch.rx_count        = res_reg.rx_count;

    `SCTRX_ASSERT_NOW(a_drive_only_tx, clk, rst_n, eng_result.line_drive, status.mode == MODE_TX)
    `SCTRX_ASSERT_NEXT(a_taken_enters_tx, clk, rst_n, step && eng_result.tx_taken, status.mode == MODE_TX)
    `SCTRX_ASSERT_NEXT(a_in_stage_holds, clk, rst_n, in_full_reg && !advance, in_full_reg)
    `SCTRX_ASSERT_NOW(a_bad_byte_mark, clk, rst_n, out_ch.valid && out_ch.rx_parity_error, out_ch.rx_byte == BAD_BYTE)

endmodule

// File: hdl/sctrx_cfg_regs.sv
//------------------------------------------------------------------------------
// Smart-card character engine configuration registers
// Holds the etu divider and the response idle timeout.
//------------------------------------------------------------------------------
module sctrx_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output sctrx_pkg::cfg_t   cfg
);
    import sctrx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ETU_TICKS:    cfg_next.etu_ticks          = cfg_data;
                CFG_IDLE_TIMEOUT: cfg_next.idle_timeout_ticks = cfg_data;
                default:          cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.etu_ticks          <= ETU_RESET;
            cfg_reg.idle_timeout_ticks <= IDLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/sctrx_engine.sv
//------------------------------------------------------------------------------
// Smart-card character engine state machine
// One tick per step: frame transmit, error-signal sample, receive and timeout.
//------------------------------------------------------------------------------
module sctrx_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  sctrx_pkg::cfg_t      cfg,
    input  sctrx_pkg::item_t     item,
    output sctrx_pkg::result_t   result,
    output sctrx_pkg::status_t   status
);
    import sctrx_pkg::*;

    mode_t       mode_reg,       mode_next;
    logic [15:0] etu_cnt_reg,    etu_cnt_next;
    logic [3:0]  phase_reg,      phase_next;
    logic [7:0]  tx_shift_reg,   tx_shift_next;
    logic        parity_reg,     parity_next;
    logic        last_pend_reg,  last_pend_next;
    logic [7:0]  rx_shift_reg,   rx_shift_next;
    logic [3:0]  rx_bit_reg,     rx_bit_next;
    logic [15:0] idle_cnt_reg,   idle_cnt_next;
    logic [7:0]  byte_count_reg, byte_count_next;

    logic [15:0] etu;
    logic [15:0] half;
    logic        etu_end;
    logic        at_half;
    logic [15:0] idle_lim;
    logic [15:0] idle_inc;
    logic        idle_hit;
    logic        tx_data_phase;
    logic        rx_bad;
    logic        guard_end;
    logic        timeout_end;
    logic        count_end;

    // a zero divider or timeout acts as one
    assign etu      = (cfg.etu_ticks == 16'd0) ? 16'd1 : cfg.etu_ticks;
    assign half     = etu >> 1;
    assign etu_end  = ({1'b0, etu_cnt_reg} + 17'd1) >= {1'b0, etu};
    assign at_half  = (etu_cnt_reg == half);
    assign idle_lim = (cfg.idle_timeout_ticks == 16'd0) ? 16'd1 : cfg.idle_timeout_ticks;
    assign idle_inc = idle_cnt_reg + 16'd1;
    assign idle_hit = (idle_inc >= idle_lim);

    assign tx_data_phase = (phase_reg >= PH_DATA_LO) && (phase_reg <= PH_DATA_HI);
    assign rx_bad        = parity_reg ^ item.line_in;
    assign guard_end     = (rx_bit_reg != RXB_WAIT) && at_half && (rx_bit_reg >= RXB_GUARD);
    assign timeout_end   = (rx_bit_reg == RXB_WAIT) && item.line_in
                           && (byte_count_reg != 8'd0) && idle_hit;
    assign count_end     = guard_end && (byte_count_reg >= MAX_RESPONSE);

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        etu_cnt_next    = etu_cnt_reg;
        phase_next      = phase_reg;
        tx_shift_next   = tx_shift_reg;
        parity_next     = parity_reg;
        last_pend_next  = last_pend_reg;
        rx_shift_next   = rx_shift_reg;
        rx_bit_next     = rx_bit_reg;
        idle_cnt_next   = idle_cnt_reg;
        byte_count_next = byte_count_reg;

        unique case (mode_reg)
            MODE_TX:
            begin
                if (etu_end)
                begin
                    etu_cnt_next = 16'd0;
                    if (tx_data_phase)
                    begin
                        parity_next   = parity_reg ^ tx_shift_reg[0];
                        tx_shift_next = tx_shift_reg >> 1;
                    end
                    if ((phase_reg == PH_END) || (phase_reg > PH_START))
                    begin
                        phase_next     = PH_START;
                        last_pend_next = 1'b0;
                        if (last_pend_reg)
                        begin
                            mode_next       = MODE_RX;
                            byte_count_next = 8'd0;
                            idle_cnt_next   = 16'd0;
                            rx_bit_next     = RXB_WAIT;
                            rx_shift_next   = 8'd0;
                            parity_next     = 1'b0;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg - 4'd1;
                    end
                end
                else
                begin
                    etu_cnt_next = etu_cnt_reg + 16'd1;
                end
            end
            MODE_RX:
            begin
                if (rx_bit_reg == RXB_WAIT)
                begin
                    if (!item.line_in)
                    begin
                        rx_bit_next   = RXB_START;
                        etu_cnt_next  = 16'd0;
                        rx_shift_next = 8'd0;
                        parity_next   = 1'b0;
                        idle_cnt_next = 16'd0;
                    end
                    else if (byte_count_reg != 8'd0)
                    begin
                        idle_cnt_next = idle_inc;
                        if (idle_hit)
                        begin
                            mode_next     = MODE_IDLE;
                            idle_cnt_next = 16'd0;
                        end
                    end
                end
                else
                begin
                    // mid-bit sample; the start bit is not checked
                    if (at_half)
                    begin
                        if ((rx_bit_reg >= RXB_DATA_LO) && (rx_bit_reg <= RXB_DATA_HI))
                        begin
                            rx_shift_next = {item.line_in, rx_shift_reg[7:1]};
                            parity_next   = parity_reg ^ item.line_in;
                        end
                        else if (rx_bit_reg == RXB_PARITY)
                        begin
                            if (byte_count_reg != BYTE_COUNT_TOP)
                            begin
                                byte_count_next = byte_count_reg + 8'd1;
                            end
                        end
                    end
                    if (guard_end)
                    begin
                        rx_bit_next   = RXB_WAIT;
                        etu_cnt_next  = 16'd0;
                        idle_cnt_next = 16'd0;
                        if (count_end)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else if (etu_end)
                    begin
                        etu_cnt_next = 16'd0;
                        rx_bit_next  = (rx_bit_reg < RXB_GUARD) ? rx_bit_reg + 4'd1 : RXB_GUARD;
                    end
                    else
                    begin
                        etu_cnt_next = etu_cnt_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (item.tx_valid)
                begin
                    tx_shift_next  = item.tx_byte;
                    last_pend_next = item.tx_last;
                    phase_next     = PH_START;
                    etu_cnt_next   = 16'd0;
                    parity_next    = 1'b0;
                    mode_next      = MODE_TX;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result                 = '0;
        result.line_out        = 1'b1;
        result.rx_count        = byte_count_next;

        unique case (mode_reg)
            MODE_TX:
            begin
                if (phase_reg == PH_START)
                begin
                    result.line_drive = 1'b1;
                    result.line_out   = 1'b0;
                end
                else if (tx_data_phase)
                begin
                    result.line_drive = 1'b1;
                    result.line_out   = tx_shift_reg[0];
                end
                else if (phase_reg == PH_PARITY)
                begin
                    result.line_drive = 1'b1;
                    result.line_out   = parity_reg;
                end
                else if ((phase_reg == PH_ERR_SAMPLE) && at_half && !item.line_in)
                begin
                    result.card_error = 1'b1;
                end
            end
            MODE_RX:
            begin
                if ((rx_bit_reg == RXB_PARITY) && at_half)
                begin
                    result.rx_valid        = 1'b1;
                    result.rx_parity_error = rx_bad;
                    result.rx_byte         = rx_bad ? BAD_BYTE : rx_shift_reg;
                end
                result.rx_done = timeout_end || count_end;
            end
            default:
            begin
                result.tx_taken = item.tx_valid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            etu_cnt_reg    <= 16'd0;
            phase_reg      <= PH_START;
            tx_shift_reg   <= 8'd0;
            parity_reg     <= 1'b0;
            last_pend_reg  <= 1'b0;
            rx_shift_reg   <= 8'd0;
            rx_bit_reg     <= RXB_WAIT;
            idle_cnt_reg   <= 16'd0;
            byte_count_reg <= 8'd0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            etu_cnt_reg    <= etu_cnt_next;
            phase_reg      <= phase_next;
            tx_shift_reg   <= tx_shift_next;
            parity_reg     <= parity_next;
            last_pend_reg  <= last_pend_next;
            rx_shift_reg   <= rx_shift_next;
            rx_bit_reg     <= rx_bit_next;
            idle_cnt_reg   <= idle_cnt_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign status.mode = mode_reg;

endmodule

// File: tb/sv/char_engine_check.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Smart-card character engine checker
// Watches the tick and result channels and the register port. Runs its own
// copy of the character engine on every accepted tick beat and compares each
// result beat, field by field, with the oldest expected result.
//------------------------------------------------------------------------------
module char_engine_check
(
    input  logic        clk,
    input  logic        rst_n,
    sctrx_in_if         in_ch,
    sctrx_out_if        out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          open_count,
    output int          fail_count
);
    import sctrx_pkg::*;

    logic [15:0] etu_reg;
    logic [15:0] tmo_reg;

    mode_t       eng_mode;
    logic [15:0] bit_tick;
    logic [3:0]  tx_phase;
    logic [7:0]  tx_bits;
    logic        par_acc;
    logic        last_flag;
    logic [7:0]  rx_bits;
    logic [3:0]  rx_pos;
    logic [15:0] quiet_ticks;
    logic [7:0]  resp_count;

    result_t     expected_ticks[$];
    result_t     beat_seen;
    result_t     beat_due;
    item_t       tick_item;
    int          fails;

    task automatic report_mismatch(input string what, input logic [7:0] seen,
                                   input logic [7:0] due);
        fails++;
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, seen, due);
    endtask

    task automatic compare_field(input string name, input logic [7:0] seen,
                                 input logic [7:0] due);
        if (seen !== due)
            report_mismatch(name, seen, due);
    endtask

    // One clock tick of the engine: advance the state, return the tick's outputs.
    task automatic tick_engine(input item_t it, output result_t r);
        int unsigned etu;
        int unsigned half;
        int unsigned lim;
        logic [3:0]  ph;
        logic [3:0]  pos;
        logic        etu_end;
        logic        bad;
        logic        rewind;

        etu     = (etu_reg == 16'd0) ? 1 : etu_reg;
        half    = etu / 2;
        etu_end = (bit_tick + 1) >= etu;
        r = '0;
        r.line_out = 1'b1;

        case (eng_mode)
            MODE_TX:
            begin
                ph = tx_phase;
                if (ph == PH_START)
                begin
                    r.line_drive = 1'b1;
                    r.line_out   = 1'b0;
                end
                else if (ph >= PH_DATA_LO && ph <= PH_DATA_HI)
                begin
                    r.line_drive = 1'b1;
                    r.line_out   = tx_bits[0];
                end
                else if (ph == PH_PARITY)
                begin
                    r.line_drive = 1'b1;
                    r.line_out   = par_acc;
                end
                else if (ph == PH_ERR_SAMPLE && bit_tick == half && !it.line_in)
                begin
                    r.card_error = 1'b1;
                end

                if (etu_end)
                begin
                    bit_tick = '0;
                    if (ph >= PH_DATA_LO && ph <= PH_DATA_HI)
                    begin
                        par_acc = par_acc ^ tx_bits[0];
                        tx_bits = tx_bits >> 1;
                    end
                    if (ph == PH_END || ph > PH_START)
                    begin
                        tx_phase = PH_START;
                        if (last_flag)
                        begin
                            eng_mode    = MODE_RX;
                            resp_count  = '0;
                            quiet_ticks = '0;
                            rx_pos      = RXB_WAIT;
                            rx_bits     = '0;
                            par_acc     = 1'b0;
                        end
                        else
                        begin
                            eng_mode = MODE_IDLE;
                        end
                        last_flag = 1'b0;
                    end
                    else
                    begin
                        tx_phase = ph - 4'd1;
                    end
                end
                else
                begin
                    bit_tick = bit_tick + 16'd1;
                end
            end

            MODE_RX:
            begin
                if (rx_pos == RXB_WAIT)
                begin
                    if (!it.line_in)
                    begin
                        rx_pos      = RXB_START;
                        bit_tick    = '0;
                        rx_bits     = '0;
                        par_acc     = 1'b0;
                        quiet_ticks = '0;
                    end
                    else if (resp_count != 8'd0)
                    begin
                        // no timeout until the first byte of the response is in
                        lim = (tmo_reg == 16'd0) ? 1 : tmo_reg;
                        quiet_ticks = quiet_ticks + 16'd1;
                        if (quiet_ticks >= lim)
                        begin
                            r.rx_done   = 1'b1;
                            eng_mode    = MODE_IDLE;
                            quiet_ticks = '0;
                        end
                    end
                end
                else
                begin
                    pos    = rx_pos;
                    rewind = 1'b0;
                    if (bit_tick == half)
                    begin
                        if (pos >= RXB_DATA_LO && pos <= RXB_DATA_HI)
                        begin
                            rx_bits = {it.line_in, rx_bits[7:1]};
                            par_acc = par_acc ^ it.line_in;
                        end
                        else if (pos == RXB_PARITY)
                        begin
                            bad               = par_acc ^ it.line_in;
                            r.rx_valid        = 1'b1;
                            r.rx_parity_error = bad;
                            r.rx_byte         = bad ? BAD_BYTE : rx_bits;
                            if (resp_count != BYTE_COUNT_TOP)
                                resp_count = resp_count + 8'd1;
                        end
                        else if (pos >= RXB_GUARD)
                        begin
                            rewind = 1'b1;
                        end
                    end

                    if (rewind)
                    begin
                        rx_pos      = RXB_WAIT;
                        bit_tick    = '0;
                        quiet_ticks = '0;
                        if (resp_count >= MAX_RESPONSE)
                        begin
                            r.rx_done = 1'b1;
                            eng_mode  = MODE_IDLE;
                        end
                    end
                    else if (etu_end)
                    begin
                        bit_tick = '0;
                        rx_pos   = (pos < RXB_GUARD) ? pos + 4'd1 : RXB_GUARD;
                    end
                    else
                    begin
                        bit_tick = bit_tick + 16'd1;
                    end
                end
            end

            default:
            begin
                eng_mode = MODE_IDLE;
                if (it.tx_valid)
                begin
                    r.tx_taken = 1'b1;
                    tx_bits    = it.tx_byte;
                    last_flag  = it.tx_last;
                    tx_phase   = PH_START;
                    bit_tick   = '0;
                    par_acc    = 1'b0;
                    eng_mode   = MODE_TX;
                end
            end
        endcase

        r.rx_count = resp_count;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etu_reg     = ETU_RESET;
            tmo_reg     = IDLE_RESET;
            eng_mode    = MODE_IDLE;
            bit_tick    = '0;
            tx_phase    = PH_START;
            tx_bits     = '0;
            par_acc     = 1'b0;
            last_flag   = 1'b0;
            rx_bits     = '0;
            rx_pos      = RXB_WAIT;
            quiet_ticks = '0;
            resp_count  = '0;
            expected_ticks.delete();
            open_count <= 0;
            fail_count <= fails;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ETU_TICKS)
                    etu_reg = cfg_data;
                else
                    tmo_reg = cfg_data;
            end

            if (out_ch.valid && out_ch.ready)
            begin
                beat_seen.line_out        = out_ch.line_out;
                beat_seen.line_drive      = out_ch.line_drive;
                beat_seen.tx_taken        = out_ch.tx_taken;
                beat_seen.card_error      = out_ch.card_error;
                beat_seen.rx_valid        = out_ch.rx_valid;
                beat_seen.rx_byte         = out_ch.rx_byte;
                beat_seen.rx_parity_error = out_ch.rx_parity_error;
                beat_seen.rx_done         = out_ch.rx_done;
                beat_seen.rx_count        = out_ch.rx_count;
                if (expected_ticks.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", beat_seen.rx_count,
                                    8'h00);
                end
                else
                begin
                    beat_due = expected_ticks.pop_front();
                    compare_field("line_out", beat_seen.line_out, beat_due.line_out);
                    compare_field("line_drive", beat_seen.line_drive, beat_due.line_drive);
                    compare_field("tx_taken", beat_seen.tx_taken, beat_due.tx_taken);
                    compare_field("card_error", beat_seen.card_error, beat_due.card_error);
                    compare_field("rx_valid", beat_seen.rx_valid, beat_due.rx_valid);
                    compare_field("rx_byte", beat_seen.rx_byte, beat_due.rx_byte);
                    compare_field("rx_parity_error", beat_seen.rx_parity_error,
                                  beat_due.rx_parity_error);
                    compare_field("rx_done", beat_seen.rx_done, beat_due.rx_done);
                    compare_field("rx_count", beat_seen.rx_count, beat_due.rx_count);
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                tick_item.line_in  = in_ch.line_in;
                tick_item.tx_valid = in_ch.tx_valid;
                tick_item.tx_byte  = in_ch.tx_byte;
                tick_item.tx_last  = in_ch.tx_last;
                tick_engine(tick_item, beat_due);
                expected_ticks.push_back(beat_due);
            end

            open_count <= expected_ticks.size();
            fail_count <= fails;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Smart-card character engine testbench
// Plays host and card around the engine one clock tick per beat: command
// bytes with and without a card error signal, card responses with good and
// bad parity, idle timeouts and a full-length response, over several etu and
// timeout settings. A separate checker predicts every result beat.
//------------------------------------------------------------------------------
module tb_top;
    import sctrx_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          open_count;
    int          fail_count;

    int          cycles = 0;
    bit          steady = 1'b0;
    int          cur_etu = ETU_RESET;
    int          cur_tmo = IDLE_RESET;
    int          tick_beats = 0;
    int          cmd_bytes = 0;
    int          error_pulses = 0;
    int          resp_bytes = 0;
    int          parity_faults = 0;
    int          exchanges = 0;
    int          reg_writes = 0;

    sctrx_in_if  in_ch ();
    sctrx_out_if out_ch ();

    smart_card_char_tx_rx_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    char_engine_check char_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .open_count (open_count),
        .fail_count (fail_count)
    );

    always #5 clk = ~clk;

    initial out_ch.ready = 1'b0;

    always @(posedge clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 33);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // One tick beat, with a random hold-off unless the run is in its steady stretch.
    task automatic drive_tick(input logic li, input logic tv, input logic [7:0] tb,
                              input logic tl);
        while (!steady && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.line_in  <= li;
        in_ch.tx_valid <= tv;
        in_ch.tx_byte  <= tb;
        in_ch.tx_last  <= tl;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        tick_beats++;
    endtask

    // Hold the line level for n ticks; offer junk bytes only where the engine is busy.
    task automatic line_ticks(input logic level, input int n, input bit tx_noise);
        for (int k = 0; k < n; k++)
            drive_tick(level, tx_noise ? 1'($urandom_range(1)) : 1'b0, 8'($urandom),
                       1'($urandom_range(1)));
    endtask

    // Drop valid and wait until every result is back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (open_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timing(input logic [15:0] etu, input logic [15:0] tmo);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ETU_TICKS;
        cfg_data  <= etu;
        @(posedge clk);
        cfg_index <= CFG_IDLE_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_etu    = (etu == 16'd0) ? 1 : etu;
        cur_tmo    = (tmo == 16'd0) ? 1 : tmo;
        reg_writes += 2;
    endtask

    // Offer a byte to the idle engine, then play the card for its 15-etu frame.
    task automatic send_command_byte(input logic [7:0] b, input logic last, input bit err);
        int span;
        int phase;
        drive_tick(1'($urandom_range(1)), 1'b1, b, last);
        cmd_bytes++;
        if (err)
            error_pulses++;
        span = 15 * cur_etu;
        for (int k = 0; k < span; k++)
        begin
            phase = 14 - k / cur_etu;
            if (phase == PH_ERR_SAMPLE)
                drive_tick(!err, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
            else
                drive_tick($urandom_range(3) != 0, 1'($urandom_range(1)), 8'($urandom),
                           1'($urandom_range(1)));
        end
    endtask

    // Card byte: start bit, data LSB first, parity, then gap ticks of idle line.
    task automatic send_card_byte(input logic [7:0] v, input bit bad, input int gap);
        logic [9:0] frame;
        frame = {(^v) ^ bad, v, 1'b0};
        for (int i = 0; i < 10; i++)
            line_ticks(frame[i], cur_etu, 1'b0);
        line_ticks(1'b1, gap, 1'b0);
        resp_bytes++;
        if (bad)
            parity_faults++;
    endtask

    // Command of n_cmd bytes, card answer of n_resp bytes, then idle until the
    // response has surely ended. A rough exchange squeezes some byte gaps.
    task automatic exchange(input int n_cmd, input int n_resp, input bit rough);
        int half;
        int gap;
        half = cur_etu / 2;
        for (int i = 0; i < n_cmd; i++)
        begin
            line_ticks(1'($urandom_range(1)), $urandom_range(2), 1'b0);
            send_command_byte(8'($urandom), i == n_cmd - 1, $urandom_range(3) == 0);
        end
        line_ticks(1'b1, $urandom_range(3 * cur_etu), 1'b1);
        for (int j = 0; j < n_resp; j++)
        begin
            if (rough && $urandom_range(3) == 0)
                gap = $urandom_range(half + 1);
            else
                gap = cur_etu + half + 2 + $urandom_range(cur_etu);
            if (j == n_resp - 1)
                gap = 0;
            send_card_byte(8'($urandom), $urandom_range(5) == 0, gap);
        end
        line_ticks(1'b1, 12 * cur_etu + cur_tmo + 4, 1'b0);
        exchanges++;
    endtask

    initial
    begin
        int rand_start;
        int n_random;
        int etu_pick;
        int tmo_pick;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_ETU_TICKS;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.line_in  <= 1'b1;
        in_ch.tx_valid <= 1'b0;
        in_ch.tx_byte  <= '0;
        in_ch.tx_last  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: one byte taken, the rest offered while busy
        drive_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        drive_tick(1'b0, 1'b1, 8'h00, 1'b1);
        drive_tick(1'b1, 1'b1, 8'h80, 1'b1);
        drive_tick(1'b0, 1'b0, 8'h01, 1'b0);
        line_ticks(1'b0, 6, 1'b1);

        // zero etu and zero timeout act as one; finish the stranded frame
        set_timing(16'd0, 16'd0);
        line_ticks(1'b1, 20, 1'b0);
        exchange(2, 2, 1'b0);

        // longest etu: start a frame, then shrink the etu under it
        set_timing(16'hFFFF, 16'hFFFF);
        drive_tick(1'b1, 1'b1, 8'h3C, 1'b0);
        line_ticks(1'b1, 30, 1'b1);
        set_timing(16'd2, 16'd5);
        line_ticks(1'b1, 40, 1'b0);
        exchange(1, 3, 1'b1);

        set_timing(16'd16, 16'd30);
        exchange(2, 3, 1'b0);

        // full-length response ends on the byte count
        set_timing(16'd3, 16'd200);
        exchange(1, 255, 1'b0);

        // longest timeout, no idling on either side
        steady = 1'b1;
        set_timing(16'd5, 16'hFFFF);
        exchange(1, 2, 1'b0);
        steady = 1'b0;

        rand_start = tick_beats;
        n_random   = 0;
        while (tick_beats - rand_start < 550 || n_random < 12)
        begin
            if (n_random % 3 == 0)
            begin
                case ($urandom_range(9))
                    0:       etu_pick = $urandom_range(2);
                    1:       etu_pick = 16;
                    default: etu_pick = $urandom_range(3, 8);
                endcase
                case ($urandom_range(5))
                    0:       tmo_pick = 0;
                    1:       tmo_pick = 1;
                    default: tmo_pick = $urandom_range(2, 60);
                endcase
                set_timing(16'(etu_pick), 16'(tmo_pick));
            end
            exchange($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(3) == 0);
            n_random++;
        end

        settle();
        $display("%0d tick beats: %0d command bytes (%0d met a card error), %0d card bytes (%0d with bad parity)",
                 tick_beats, cmd_bytes, error_pulses, resp_bytes, parity_faults);
        $display("%0d exchanges across %0d register writes, etu and timeout from zero to full scale",
                 exchanges, reg_writes);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/sctrx_pkg.sv
hdl/sctrx_if.sv
hdl/sctrx_cfg_regs.sv
hdl/sctrx_engine.sv
hdl/smart_card_char_tx_rx_core.sv
tb/sv/char_engine_check.sv
tb/sv/tb_top.sv
